FILE: sv/sbde_pkg.sv
package sbde_pkg;

   localparam int DATA_W  = 16;
   localparam int INSTR_W = 16;
   localparam int FIELD_W = 3;

   typedef logic [DATA_W-1:0] data_type;

   // Format R opcodes, bits 14:9.
   localparam logic [5:0] OP_ADD = 6'd0;
   localparam logic [5:0] OP_SUB = 6'd1;
   localparam logic [5:0] OP_MUL = 6'd2;
   localparam logic [5:0] OP_DIV = 6'd3;
   localparam logic [5:0] OP_EQ  = 6'd4;
   localparam logic [5:0] OP_NE  = 6'd5;

   // Format I opcode, bits 14:13.
   localparam logic [1:0] OP_MOVI = 2'd0;

   localparam logic FMT_R = 1'b0;

   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      data_type quotient;
   } div_rsp_type;

endpackage

FILE: sv/sbde_ram.sv
module sbde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sbde_div.sv
module sbde_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sbde_pkg::div_req_type div_req,
   output sbde_pkg::div_rsp_type div_rsp
);

   localparam int W     = sbde_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     dsr_ff;
   logic [W:0]       shifted;
   logic [W+1:0]     diff;
   logic             fits;

   // One quotient bit per cycle, restoring method.
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~diff[W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         cnt_ff <= CNT_W'(W - 1);
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= fits ? diff[W-1:0] : shifted[W-1:0];
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: sv/sixteen_bit_decode_execute.sv
// Channel  Direction  Ports                                              Handshake
// req      in         req_instr_word                                     req_valid/req_ready
// rsp      out        rsp_dest_index rsp_write_value rsp_wrote           rsp_valid/rsp_ready
//                     rsp_div_zero
//
// One word is in flight at a time. A non-divide word passes through register
// read, execute and write-back before the next word is accepted.
// A divide with a nonzero divisor also waits for the bit-serial divider, which
// produces one quotient bit per cycle.
// Reset clears the register file through per-entry valid bits.
// A stalled result waits in the output register while the next word is read.
module sixteen_bit_decode_execute #(
   parameter int REG_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_dest_index,
   output logic [15:0] rsp_write_value,
   output logic        rsp_wrote,
   output logic        rsp_div_zero
);

   localparam int IDX_W = $clog2(REG_COUNT);
   localparam int W     = sbde_pkg::DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                        state_ff;
   logic [sbde_pkg::INSTR_W-1:0]     instr_ff;
   logic [REG_COUNT-1:0]             valid_ff;
   logic                             va_ok_ff;
   logic                             vb_ok_ff;
   logic [sbde_pkg::FIELD_W-1:0]     dest_ff;
   sbde_pkg::data_type               val_ff;
   logic                             wr_ff;
   logic                             dz_ff;
   logic                             rsp_valid_ff;
   logic [sbde_pkg::FIELD_W-1:0]     rsp_dest_ff;
   sbde_pkg::data_type               rsp_val_ff;
   logic                             rsp_wr_ff;
   logic                             rsp_dz_ff;

   logic [IDX_W-1:0]                 ra_idx;
   logic [IDX_W-1:0]                 rb_idx;
   sbde_pkg::data_type               ram_a_q;
   sbde_pkg::data_type               ram_b_q;
   sbde_pkg::data_type               op_a;
   sbde_pkg::data_type               op_b;
   logic [2*W-1:0]                   prod;
   logic [sbde_pkg::FIELD_W-1:0]     ex_dest;
   sbde_pkg::data_type               ex_val;
   logic                             ex_wr;
   logic                             ex_dz;
   logic                             ex_div_go;
   logic                             accept;
   logic                             retire;
   logic                             ram_we;
   sbde_pkg::div_req_type            div_req;
   sbde_pkg::div_rsp_type            div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign retire    = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign ram_we    = retire && wr_ff;

   assign ra_idx = req_instr_word[3 +: IDX_W];
   assign rb_idx = req_instr_word[0 +: IDX_W];

   // Two copies of the register file give two read ports.
   sbde_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_ram_a (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dest_ff[IDX_W-1:0]),
      .wr_data (val_ff),
      .rd_addr (ra_idx),
      .rd_data (ram_a_q)
   );

   sbde_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dest_ff[IDX_W-1:0]),
      .wr_data (val_ff),
      .rd_addr (rb_idx),
      .rd_data (ram_b_q)
   );

   always_comb begin
      op_a      = va_ok_ff ? ram_a_q : '0;
      op_b      = vb_ok_ff ? ram_b_q : '0;
      prod      = op_a * op_b;
      ex_val    = '0;
      ex_wr     = 1'b0;
      ex_dz     = 1'b0;
      ex_div_go = 1'b0;
      if (instr_ff[15] == sbde_pkg::FMT_R) begin
         ex_dest = instr_ff[8:6];
         ex_wr   = 1'b1;
         unique case (instr_ff[14:9])
            sbde_pkg::OP_ADD: ex_val = op_a + op_b;
            sbde_pkg::OP_SUB: ex_val = op_a - op_b;
            sbde_pkg::OP_MUL: ex_val = prod[W-1:0];
            sbde_pkg::OP_DIV: begin
               if (op_b == '0) begin
                  ex_val = '1;
                  ex_dz  = 1'b1;
               end else begin
                  ex_div_go = 1'b1;
               end
            end
            sbde_pkg::OP_EQ: ex_val = W'(op_a == op_b);
            sbde_pkg::OP_NE: ex_val = W'(op_a != op_b);
            default: ex_wr = 1'b0;
         endcase
      end else begin
         ex_dest = instr_ff[12:10];
         if (instr_ff[14:13] == sbde_pkg::OP_MOVI) begin
            ex_val = W'(instr_ff[9:0]);
            ex_wr  = 1'b1;
         end
      end
   end

   always_comb begin
      div_req.start    = (state_ff == ST_READ) && ex_div_go;
      div_req.dividend = op_a;
      div_req.divisor  = op_b;
   end

   sbde_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (retire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  instr_ff <= req_instr_word;
                  va_ok_ff <= valid_ff[ra_idx];
                  vb_ok_ff <= valid_ff[rb_idx];
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               dest_ff  <= ex_dest;
               val_ff   <= ex_val;
               wr_ff    <= ex_wr;
               dz_ff    <= ex_dz;
               state_ff <= ex_div_go ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  val_ff   <= div_rsp.quotient;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (retire) begin
                  rsp_dest_ff  <= dest_ff;
                  rsp_val_ff   <= val_ff;
                  rsp_wr_ff    <= wr_ff;
                  rsp_dz_ff    <= dz_ff;
                  if (wr_ff) begin
                     valid_ff[dest_ff[IDX_W-1:0]] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_index  = rsp_dest_ff;
   assign rsp_write_value = rsp_val_ff;
   assign rsp_wrote       = rsp_wr_ff;
   assign rsp_div_zero    = rsp_dz_ff;

   a_dz_forces_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_wrote && (rsp_write_value == '1))
      else $error("divide-by-zero word without an all-ones write");

   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wrote |-> (rsp_write_value == '0) && !rsp_div_zero)
      else $error("word without a write carries a nonzero value");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide wait");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second word accepted while one is in flight");

endmodule
